@@ src/impact_hit_detector_macros.svh @@
// assertion helpers for the impact hit detector
`ifndef IMPACT_HIT_DETECTOR_MACROS_SVH
`define IMPACT_HIT_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
// property checked with reset masked
`define IHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// property checked on every edge, reset included
`define IHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IHD_ASSERT(label, prop, msg)
`define IHD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/ihd_pkg.sv @@
package ihd_pkg;

  // history ring and window sizing
  localparam int unsigned HIST_DEPTH     = 64;
  localparam int unsigned HIST_AW        = $clog2(HIST_DEPTH);
  localparam int unsigned SAMPLES_PER_MS = 10;
  localparam int unsigned WIN_W          = $clog2(63 * SAMPLES_PER_MS + 1);
  localparam int unsigned CNT_W          = $clog2(HIST_DEPTH + 1);

  // arithmetic constants
  localparam logic [31:0] MS_PER_MIN    = 32'd60000;
  localparam logic [13:0] TEMPO_SPAN_MS = 14'd10000;
  localparam logic [21:0] TEMPO_NOW_MAX = 22'd3840000;
  localparam logic [9:0]  SCORE_MAX     = 10'd999;
  localparam logic [11:0] PEAK_MAX      = 12'd4095;
  localparam logic [15:0] SAT16         = 16'hFFFF;

  // item kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  // session modes
  localparam logic [2:0] MODE_UNTIMED = 3'd0;
  localparam logic [2:0] MODE_10S     = 3'd1;
  localparam logic [2:0] MODE_20S     = 3'd2;
  localparam logic [2:0] MODE_30S     = 3'd3;
  localparam logic [2:0] MODE_60S     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_LOCKOUT    = 2'd1;
  localparam logic [1:0] REG_SERIES_GAP = 2'd2;
  localparam logic [1:0] REG_WINDOW     = 2'd3;
  localparam int unsigned CFG_W = 14;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [11:0] sample;
    logic [2:0]  session_mode;
  } in_item_t;

  typedef struct packed {
    logic        running;
    logic [2:0]  mode;
    logic [15:0] remain_ms;
    logic [15:0] hit_count;
    logic [21:0] tempo_now;
    logic [31:0] tempo_average;
    logic [15:0] current_series;
    logic [15:0] longest_series;
    logic [11:0] recent_peak;
    logic [9:0]  recent_score;
    logic [11:0] top_peak;
    logic [9:0]  top_score;
  } out_item_t;

  // session length for a mode
  function automatic logic [15:0] mode_duration(input logic [2:0] m);
    logic [15:0] r;
    case (m)
      MODE_10S: r = 16'd10000;
      MODE_20S: r = 16'd20000;
      MODE_30S: r = 16'd30000;
      MODE_60S: r = 16'd60000;
      default:  r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/ihd_if.sv @@
// input item channel
interface ihd_in_if;
  logic               valid;
  logic               ready;
  ihd_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// result item channel
interface ihd_out_if;
  logic               valid;
  logic               ready;
  ihd_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/impact_hit_detector.sv @@
// Impact hit detector. Items are taken one at a time: a sample, start or stop
// leaves the block ready; a sample that closes a window with a hit runs the
// shared 32-bit divider (one bit per cycle) that scales the score; a query while
// running walks the 64-entry history memory with one registered read per cycle,
// then divides for tempo now (unless its window is empty) and for the average
// (unless there is nothing to average) and loads the output register; when
// stopped, it divides for the average only, unless there is nothing to average.
// A finished result sits in an output register, so new items are accepted
// while it waits; a second query waits only for that register to empty.
`include "impact_hit_detector_macros.svh"

module impact_hit_detector (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [ihd_pkg::CFG_W-1:0] cfg_data_i,
  ihd_in_if.sink               in_i,
  ihd_out_if.source            out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCORE = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_NOW   = 3'd3;
  localparam logic [2:0] ST_AVG   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam int unsigned AW = ihd_pkg::HIST_AW;
  localparam int unsigned WW = ihd_pkg::WIN_W;
  localparam int unsigned CW = ihd_pkg::CNT_W;
  localparam int unsigned HIST_DEPTH_W = ihd_pkg::HIST_DEPTH;

  // configuration
  logic [11:0] thr_q;
  logic [12:0] lock_q;
  logic [13:0] gap_q;
  logic [5:0]  swin_q;

  // session state
  logic [2:0]  state_q;
  logic        active_q, ever_q;
  logic [2:0]  mode_q;
  logic [31:0] start_q, stop_q, prev_hit_q, blocked_q;
  logic [15:0] dur_q, hits_q, series_q, series_best_q;
  logic [11:0] peak_last_q, peak_best_q, wpeak_q;
  logic [9:0]  score_last_q, score_best_q;
  logic [HIST_DEPTH_W-1:0] hvalid_q;
  logic [AW-1:0] hptr_q;
  logic [WW-1:0] wcnt_q;

  // history memory
  logic [31:0] hist_mem [ihd_pkg::HIST_DEPTH];
  logic [31:0] hist_rdata_q;
  logic        hist_we;

  // pending hit and query
  logic [31:0] hit_now_q;
  logic [11:0] hit_peak_q;
  logic [31:0] qnow_q, qdur_q;
  logic [13:0] qwin_q;
  logic [15:0] qleft_q;
  logic        qactive_q, qavg_zero_q;
  logic [21:0] tnow_q;
  logic [31:0] tavg_q;
  logic [AW:0] walk_q;
  logic [AW-1:0] rd_idx_q;
  logic        rd_pend_q;
  logic [CW-1:0] cnt_q;

  // divider
  logic [31:0] div_num_q, div_den_q, div_rem_q;
  logic [4:0]  div_cnt_q;

  // output register
  logic                out_valid_q;
  ihd_pkg::out_item_t  out_q;

  ihd_pkg::in_item_t in_item;
  logic in_acc;
  assign in_item = in_i.payload;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  // divider step
  logic [32:0] div_tmp;
  logic        div_ge;
  logic [31:0] div_rem_n, div_num_n;
  logic        div_last;
  always_comb begin
    div_tmp   = {div_rem_q, div_num_q[31]};
    div_ge    = div_tmp >= {1'b0, div_den_q};
    div_rem_n = div_ge ? 32'(div_tmp - {1'b0, div_den_q}) : div_tmp[31:0];
    div_num_n = {div_num_q[30:0], div_ge};
    div_last  = &div_cnt_q;
  end

  // window and hit decision on a sample
  logic [5:0]    win_ms;
  logic [WW-1:0] win_len, wcnt_n;
  logic [11:0]   wpeak_n;
  logic          win_done, expired, lock_ok, hit;
  logic [31:0]   el_now, lock_d;
  always_comb begin
    win_ms   = (swin_q == 6'd0) ? 6'd1 : swin_q;
    win_len  = WW'(win_ms * ihd_pkg::SAMPLES_PER_MS);
    wpeak_n  = (in_item.sample > wpeak_q) ? in_item.sample : wpeak_q;
    wcnt_n   = WW'(wcnt_q + 1'b1);
    win_done = wcnt_n >= win_len;
    el_now   = in_item.now_ms - start_q;
    expired  = (dur_q != 16'd0) && (el_now >= {16'd0, dur_q});
    lock_d   = in_item.now_ms - blocked_q;
    lock_ok  = (hits_q == 16'd0) || ((lock_d != 32'd0) && !lock_d[31]);
    hit      = win_done && (wpeak_n > thr_q) && lock_ok;
  end

  // query figures
  logic [31:0] q_end, q_dur;
  logic [13:0] q_win;
  logic [15:0] q_left;
  always_comb begin
    q_win  = (el_now < {18'd0, ihd_pkg::TEMPO_SPAN_MS}) ? el_now[13:0]
                                                        : ihd_pkg::TEMPO_SPAN_MS;
    q_left = 16'd0;
    if (active_q && dur_q != 16'd0 && el_now < {16'd0, dur_q}) begin
      q_left = 16'(dur_q - el_now[15:0]);
    end
    q_end = active_q ? in_item.now_ms : stop_q;
    q_dur = q_end - start_q;
  end

  // hit bookkeeping at the end of the score division
  logic [9:0]  score_n;
  logic [15:0] series_n;
  logic [31:0] hit_gap;
  always_comb begin
    score_n  = (div_num_n > {22'd0, ihd_pkg::SCORE_MAX}) ? ihd_pkg::SCORE_MAX
                                                         : div_num_n[9:0];
    hit_gap  = hit_now_q - prev_hit_q;
    series_n = 16'd1;
    if (hits_q != 16'd0 && hit_gap <= {18'd0, gap_q}) begin
      series_n = (series_q == ihd_pkg::SAT16) ? series_q : 16'(series_q + 1'b1);
    end
    hist_we  = (state_q == ST_SCORE) && div_last;
  end

  // history walk counting
  logic          rd_in_win;
  logic [CW-1:0] cnt_n;
  logic [31:0]   age;
  always_comb begin
    age       = qnow_q - hist_rdata_q;
    rd_in_win = rd_pend_q && hvalid_q[rd_idx_q] && (age <= {18'd0, qwin_q});
    cnt_n     = rd_in_win ? CW'(cnt_q + 1'b1) : cnt_q;
  end

  // history memory ports
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hptr_q] <= hit_now_q;
    end
    hist_rdata_q <= hist_mem[walk_q[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 12'd1200; lock_q <= 13'd120; gap_q <= 14'd600; swin_q <= 6'd8;
      state_q <= ST_IDLE; active_q <= 1'b0; ever_q <= 1'b0; mode_q <= 3'd0;
      start_q <= '0; stop_q <= '0; prev_hit_q <= '0; blocked_q <= '0;
      dur_q <= '0; hits_q <= '0; series_q <= '0; series_best_q <= '0;
      peak_last_q <= '0; peak_best_q <= '0; wpeak_q <= '0;
      score_last_q <= '0; score_best_q <= '0; hvalid_q <= '0; hptr_q <= '0;
      wcnt_q <= '0; hit_now_q <= '0; hit_peak_q <= '0; qnow_q <= '0;
      qdur_q <= '0; qwin_q <= '0; qleft_q <= '0; qactive_q <= 1'b0;
      qavg_zero_q <= 1'b0; tnow_q <= '0; tavg_q <= '0; walk_q <= '0;
      rd_idx_q <= '0; rd_pend_q <= 1'b0; cnt_q <= '0;
      div_num_q <= '0; div_den_q <= '0; div_rem_q <= '0; div_cnt_q <= '0;
      out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ihd_pkg::REG_THRESHOLD:  thr_q  <= cfg_data_i[11:0];
          ihd_pkg::REG_LOCKOUT:    lock_q <= cfg_data_i[12:0];
          ihd_pkg::REG_SERIES_GAP: gap_q  <= cfg_data_i[13:0];
          ihd_pkg::REG_WINDOW:     swin_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end

      // result taken, unless a new one is loaded in the same cycle
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_item.kind)
              ihd_pkg::KIND_SAMPLE: begin
                if (active_q) begin
                  if (expired) begin
                    active_q <= 1'b0;
                    stop_q   <= in_item.now_ms;
                  end else begin
                    wpeak_q <= win_done ? 12'd0 : wpeak_n;
                    wcnt_q  <= win_done ? '0 : wcnt_n;
                    if (hit) begin
                      hit_peak_q <= wpeak_n;
                      hit_now_q  <= in_item.now_ms;
                      div_num_q  <= {10'd0, 22'(wpeak_n - thr_q) * 22'(ihd_pkg::SCORE_MAX)};
                      div_den_q  <= {20'd0, 12'(ihd_pkg::PEAK_MAX - thr_q)};
                      div_rem_q  <= '0;
                      div_cnt_q  <= '0;
                      state_q    <= ST_SCORE;
                    end
                  end
                end
              end
              ihd_pkg::KIND_START: begin
                if (in_item.session_mode <= ihd_pkg::MODE_60S) begin
                  mode_q <= in_item.session_mode;
                  dur_q  <= ihd_pkg::mode_duration(in_item.session_mode);
                  start_q <= in_item.now_ms; stop_q <= '0;
                  hits_q <= '0; prev_hit_q <= '0; blocked_q <= '0;
                  series_q <= '0; series_best_q <= '0;
                  peak_last_q <= '0; score_last_q <= '0;
                  peak_best_q <= '0; score_best_q <= '0;
                  hvalid_q <= '0; hptr_q <= '0; wpeak_q <= '0; wcnt_q <= '0;
                  active_q <= 1'b1; ever_q <= 1'b1;
                end
              end
              ihd_pkg::KIND_STOP: begin
                active_q <= 1'b0;
                stop_q   <= in_item.now_ms;
              end
              default: begin
                qnow_q      <= in_item.now_ms;
                qwin_q      <= q_win;
                qleft_q     <= q_left;
                qdur_q      <= q_dur;
                qactive_q   <= active_q;
                qavg_zero_q <= (hits_q == 16'd0) || !ever_q || (q_dur == 32'd0);
                if (active_q) begin
                  walk_q    <= '0;
                  rd_pend_q <= 1'b0;
                  cnt_q     <= '0;
                  state_q   <= ST_WALK;
                end else if ((hits_q == 16'd0) || !ever_q || (q_dur == 32'd0)) begin
                  tavg_q  <= '0;
                  tnow_q  <= '0;
                  state_q <= ST_OUT;
                end else begin
                  div_num_q <= 32'(hits_q * ihd_pkg::MS_PER_MIN);
                  div_den_q <= q_dur;
                  div_rem_q <= '0;
                  div_cnt_q <= '0;
                  state_q   <= ST_AVG;
                end
              end
            endcase
          end
        end

        ST_SCORE: begin
          div_num_q <= div_num_n; div_rem_q <= div_rem_n;
          div_cnt_q <= 5'(div_cnt_q + 1'b1);
          if (div_last) begin
            if (hits_q != ihd_pkg::SAT16) hits_q <= 16'(hits_q + 1'b1);
            series_q <= series_n;
            if (series_n > series_best_q) series_best_q <= series_n;
            prev_hit_q   <= hit_now_q;
            blocked_q    <= hit_now_q + {19'd0, lock_q};
            peak_last_q  <= hit_peak_q;
            score_last_q <= score_n;
            if (hit_peak_q > peak_best_q) peak_best_q <= hit_peak_q;
            if (score_n > score_best_q) score_best_q <= score_n;
            hvalid_q[hptr_q] <= 1'b1;
            hptr_q  <= (32'(hptr_q) + 32'd1 >= ihd_pkg::HIST_DEPTH) ? '0
                                                                  : AW'(hptr_q + 1'b1);
            state_q <= ST_IDLE;
          end
        end

        ST_WALK: begin
          cnt_q     <= cnt_n;
          rd_idx_q  <= walk_q[AW-1:0];
          rd_pend_q <= 32'(walk_q) < ihd_pkg::HIST_DEPTH;
          if (32'(walk_q) < ihd_pkg::HIST_DEPTH) walk_q <= (AW+1)'(walk_q + 1'b1);
          if (32'(walk_q) == ihd_pkg::HIST_DEPTH && rd_pend_q) begin
            if (qwin_q == 14'd0) begin
              tnow_q <= '0;
              if (qavg_zero_q) begin
                tavg_q  <= '0;
                state_q <= ST_OUT;
              end else begin
                div_num_q <= 32'(hits_q * ihd_pkg::MS_PER_MIN);
                div_den_q <= qdur_q;
                div_rem_q <= '0; div_cnt_q <= '0;
                state_q   <= ST_AVG;
              end
            end else begin
              div_num_q <= 32'(cnt_n * ihd_pkg::MS_PER_MIN);
              div_den_q <= {18'd0, qwin_q};
              div_rem_q <= '0; div_cnt_q <= '0;
              state_q   <= ST_NOW;
            end
          end
        end

        ST_NOW: begin
          if (div_last) begin
            tnow_q <= div_num_n[21:0];
            if (qavg_zero_q) begin
              tavg_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              div_num_q <= 32'(hits_q * ihd_pkg::MS_PER_MIN);
              div_den_q <= qdur_q;
              div_rem_q <= '0; div_cnt_q <= '0;
              state_q   <= ST_AVG;
            end
          end else begin
            div_num_q <= div_num_n; div_rem_q <= div_rem_n;
            div_cnt_q <= 5'(div_cnt_q + 1'b1);
          end
        end

        ST_AVG: begin
          div_num_q <= div_num_n; div_rem_q <= div_rem_n;
          div_cnt_q <= 5'(div_cnt_q + 1'b1);
          if (div_last) begin
            tavg_q <= div_num_n;
            if (!qactive_q) begin
              tnow_q <= (div_num_n > {10'd0, ihd_pkg::TEMPO_NOW_MAX})
                        ? ihd_pkg::TEMPO_NOW_MAX : div_num_n[21:0];
            end
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q          <= 1'b1;
            out_q.running        <= qactive_q;
            out_q.mode           <= mode_q;
            out_q.remain_ms      <= qleft_q;
            out_q.hit_count      <= hits_q;
            out_q.tempo_now      <= tnow_q;
            out_q.tempo_average  <= tavg_q;
            out_q.current_series <= series_q;
            out_q.longest_series <= series_best_q;
            out_q.recent_peak    <= peak_last_q;
            out_q.recent_score   <= score_last_q;
            out_q.top_peak       <= peak_best_q;
            out_q.top_score      <= score_best_q;
            state_q              <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  `IHD_ASSERT(busy_blocks_input, (state_q != ST_IDLE) |-> !in_i.ready, "input taken while busy")
  `IHD_ASSERT(div_den_nonzero, ((state_q == ST_SCORE) || (state_q == ST_NOW) || (state_q == ST_AVG)) |-> (div_den_q != 32'd0), "division by zero")
  `IHD_ASSERT(best_score_range, (score_best_q <= ihd_pkg::SCORE_MAX) && (score_last_q <= ihd_pkg::SCORE_MAX), "score out of range")
  `IHD_ASSERT_ALWAYS(walk_bound, 32'(walk_q) <= ihd_pkg::HIST_DEPTH, "history walk overran")

endmodule

@@ sim/tb_impact_hit_detector.sv @@
module tb_impact_hit_detector;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [ihd_pkg::CFG_W-1:0] cfg_data_i;

  ihd_in_if  in_ch ();
  ihd_out_if out_ch ();

  impact_hit_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  ihd_pkg::in_item_t  pending_items[$];
  ihd_pkg::out_item_t expected_status[$];
  int        errors = 0;
  bit        calm   = 0;
  int        send_gap  = 0;
  int        stall_gap = 0;

  // detector settings as the block holds them
  logic [11:0] cfg_thr  = 12'd1200;
  logic [12:0] cfg_lock = 13'd120;
  logic [13:0] cfg_gap  = 14'd600;
  logic [5:0]  cfg_win  = 6'd8;

  // session state of the predictor, at its reset values
  bit          sess_on, sess_seen;
  logic [2:0]  sess_mode = '0;
  logic [31:0] t_start = '0, t_stop = '0, last_hit = '0, lock_end = '0;
  logic [15:0] sess_len = '0, hits = '0, streak = '0, streak_best = '0;
  logic [11:0] pk_last = '0, pk_top = '0, win_pk = '0;
  logic [9:0]  sc_last = '0, sc_top = '0;
  logic [31:0] hist_t[ihd_pkg::HIST_DEPTH];
  bit          hist_v[ihd_pkg::HIST_DEPTH];
  int          hist_ptr, win_n;

  // clock, and every input known from time zero
  initial begin
    clk_i = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = ihd_pkg::REG_THRESHOLD;
    cfg_data_i = '0;
    in_ch.valid = 0;
    in_ch.payload = '0;
    out_ch.ready = 0;
    forever #5 clk_i = ~clk_i;
  end

  // reset held low from time zero, then released
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
  end

  // run time limit
  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [9:0] hit_score(logic [11:0] pk);
    logic [31:0] span;
    longint unsigned s;
    if (pk <= cfg_thr) return 10'd0;
    span = 32'd4095 - cfg_thr;
    if (span == 0) return 10'd999;
    s = (longint'(pk - cfg_thr) * 999) / span;
    return (s > 999) ? 10'd999 : s[9:0];
  endfunction

  function automatic logic [31:0] session_rate(logic [31:0] end_ms);
    logic [31:0] dur;
    longint unsigned r;
    if (hits == 0 || !sess_seen) return 32'd0;
    dur = end_ms - t_start;
    if (dur == 0) return 32'd0;
    r = (longint'(hits) * 60000) / dur;
    return r[31:0];
  endfunction

  function automatic logic [21:0] recent_rate(logic [31:0] now);
    logic [31:0] el, span, age;
    longint unsigned n;
    el = now - t_start;
    span = (el < 32'd10000) ? el : 32'd10000;
    n = 0;
    if (span == 0) return 22'd0;
    for (int i = 0; i < ihd_pkg::HIST_DEPTH; i++) begin
      age = now - hist_t[i];
      if (hist_v[i] && age <= span) n++;
    end
    n = (n * 60000) / span;
    return n[21:0];
  endfunction

  task automatic log_hit(logic [31:0] now, logic [11:0] pk);
    logic [9:0] sc;
    logic [31:0] gap;
    bit first;
    sc = hit_score(pk);
    first = (hits == 0);
    gap = now - last_hit;
    if (hits != 16'hFFFF) hits++;
    if (!first && gap <= cfg_gap) begin
      if (streak != 16'hFFFF) streak++;
    end else begin
      streak = 1;
    end
    if (streak > streak_best) streak_best = streak;
    last_hit = now;
    lock_end = now + cfg_lock;
    pk_last = pk;
    sc_last = sc;
    if (pk > pk_top) pk_top = pk;
    if (sc > sc_top) sc_top = sc;
    hist_t[hist_ptr] = now;
    hist_v[hist_ptr] = 1;
    hist_ptr = (hist_ptr + 1) % ihd_pkg::HIST_DEPTH;
  endtask

  // advances the predicted detector by one accepted transaction
  task automatic advance_detector(ihd_pkg::in_item_t it);
    logic [31:0] el, d;
    ihd_pkg::out_item_t st;
    int win_len;
    case (it.kind)
      ihd_pkg::KIND_SAMPLE: begin
        if (sess_on) begin
          el = it.now_ms - t_start;
          if (sess_len != 0 && el >= sess_len) begin
            sess_on = 0;
            t_stop = it.now_ms;
          end else begin
            win_len = ((cfg_win == 0) ? 1 : cfg_win) * ihd_pkg::SAMPLES_PER_MS;
            if (it.sample > win_pk) win_pk = it.sample;
            win_n++;
            if (win_n >= win_len) begin
              d = it.now_ms - lock_end;
              if (win_pk > cfg_thr && (hits == 0 || (d != 0 && !d[31])))
                log_hit(it.now_ms, win_pk);
              win_pk = 0;
              win_n = 0;
            end
          end
        end
      end
      ihd_pkg::KIND_START: begin
        if (it.session_mode <= ihd_pkg::MODE_60S) begin
          sess_mode = it.session_mode;
          case (it.session_mode)
            ihd_pkg::MODE_10S: sess_len = 16'd10000;
            ihd_pkg::MODE_20S: sess_len = 16'd20000;
            ihd_pkg::MODE_30S: sess_len = 16'd30000;
            ihd_pkg::MODE_60S: sess_len = 16'd60000;
            default:           sess_len = 16'd0;
          endcase
          t_start = it.now_ms;
          t_stop = 0;
          hits = 0; last_hit = 0; lock_end = 0;
          streak = 0; streak_best = 0;
          pk_last = 0; sc_last = 0; pk_top = 0; sc_top = 0;
          for (int i = 0; i < ihd_pkg::HIST_DEPTH; i++) hist_v[i] = 0;
          hist_ptr = 0; win_pk = 0; win_n = 0;
          sess_on = 1;
          sess_seen = 1;
        end
      end
      ihd_pkg::KIND_STOP: begin
        sess_on = 0;
        t_stop = it.now_ms;
      end
      default: begin
        st = '0;
        if (sess_on && sess_len != 0) begin
          el = it.now_ms - t_start;
          st.remain_ms = (el >= sess_len) ? 16'd0 : 16'(sess_len - el);
        end
        if (sess_on) begin
          st.tempo_now = recent_rate(it.now_ms);
          st.tempo_average = session_rate(it.now_ms);
        end else begin
          st.tempo_average = session_rate(t_stop);
          st.tempo_now = (st.tempo_average > ihd_pkg::TEMPO_NOW_MAX)
                         ? ihd_pkg::TEMPO_NOW_MAX : st.tempo_average[21:0];
        end
        st.running = sess_on;
        st.mode = sess_mode;
        st.hit_count = hits;
        st.current_series = streak;
        st.longest_series = streak_best;
        st.recent_peak = pk_last;
        st.recent_score = sc_last;
        st.top_peak = pk_top;
        st.top_score = sc_top;
        expected_status.push_back(st);
      end
    endcase
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 0;
      in_ch.payload <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) advance_detector(in_ch.payload);
      if (in_ch.valid && !in_ch.ready) begin
        // holding the offered transaction
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 0;
      end else if (pending_items.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_ch.valid <= 0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid <= 1;
        in_ch.payload <= pending_items.pop_front();
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endfunction

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    ihd_pkg::out_item_t e, a;
    if (!rst_ni) begin
      out_ch.ready <= 0;
      stall_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.payload;
        if (expected_status.size() == 0) begin
          $error("status transaction with none expected");
          errors++;
        end else begin
          e = expected_status.pop_front();
          check_field("running", e.running, a.running);
          check_field("mode", e.mode, a.mode);
          check_field("remain_ms", e.remain_ms, a.remain_ms);
          check_field("hit_count", e.hit_count, a.hit_count);
          check_field("tempo_now", e.tempo_now, a.tempo_now);
          check_field("tempo_average", e.tempo_average, a.tempo_average);
          check_field("current_series", e.current_series, a.current_series);
          check_field("longest_series", e.longest_series, a.longest_series);
          check_field("recent_peak", e.recent_peak, a.recent_peak);
          check_field("recent_score", e.recent_score, a.recent_score);
          check_field("top_peak", e.top_peak, a.top_peak);
          check_field("top_score", e.top_score, a.top_score);
        end
      end
      if (stall_gap > 0) begin
        stall_gap--;
        out_ch.ready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_gap = $urandom_range(0, 3);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // stimulus
  logic [31:0] clock_ms = 32'd1000;
  bit          tb_sess  = 0;

  task automatic push_item(logic [1:0] k, logic [11:0] smp, logic [2:0] m);
    ihd_pkg::in_item_t it;
    it.kind = k;
    it.now_ms = clock_ms;
    it.sample = smp;
    it.session_mode = m;
    pending_items.push_back(it);
  endtask

  // sender holds off until the block has drained completely
  task automatic drain();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || expected_status.size() != 0);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [11:0] thr, logic [12:0] lck, logic [13:0] gp,
                                logic [5:0] wn);
    drain();
    cfg_thr = thr; cfg_lock = lck; cfg_gap = gp; cfg_win = wn;
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= ihd_pkg::REG_THRESHOLD;
    cfg_data_i <= ihd_pkg::CFG_W'(thr);
    @(posedge clk_i);
    cfg_idx_i <= ihd_pkg::REG_LOCKOUT; cfg_data_i <= ihd_pkg::CFG_W'(lck);
    @(posedge clk_i);
    cfg_idx_i <= ihd_pkg::REG_SERIES_GAP; cfg_data_i <= ihd_pkg::CFG_W'(gp);
    @(posedge clk_i);
    cfg_idx_i <= ihd_pkg::REG_WINDOW; cfg_data_i <= ihd_pkg::CFG_W'(wn);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_traffic(int n);
    int r;
    logic [2:0] m;
    logic [11:0] smp;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 199) == 0) clock_ms += $urandom();
      else if ($urandom_range(0, 99) == 0) clock_ms += $urandom_range(5000, 61000);
      if (!tb_sess && r < 60 || r < 3) begin
        m = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        push_item(ihd_pkg::KIND_START, 12'($urandom()), m);
        tb_sess = (m <= ihd_pkg::MODE_60S);
      end else if (r < 6) begin
        push_item(ihd_pkg::KIND_STOP, 12'($urandom()), 3'($urandom()));
        tb_sess = 0;
      end else if (r < 18) begin
        push_item(ihd_pkg::KIND_QUERY, 12'($urandom()), 3'($urandom()));
      end else begin
        clock_ms += $urandom_range(0, 3);
        smp = ($urandom_range(0, 5) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 800));
        push_item(ihd_pkg::KIND_SAMPLE, smp, 3'($urandom()));
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    random_traffic(120);

    // short windows for the hand-picked cases
    write_settings(12'd0, 13'd0, 14'd0, 6'd0);
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_START, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    for (int i = 0; i < 10; i++) begin
      clock_ms += 1;
      push_item(ihd_pkg::KIND_SAMPLE, (i == 4) ? 12'd4095 : 12'd0, ihd_pkg::MODE_UNTIMED);
    end
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_STOP, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_STOP, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_START, 12'd0, 3'd7);
    push_item(ihd_pkg::KIND_START, 12'd0, ihd_pkg::MODE_10S);
    clock_ms += 10000;
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_SAMPLE, 12'd4095, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    push_item(ihd_pkg::KIND_START, 12'd0, ihd_pkg::MODE_60S);
    push_item(ihd_pkg::KIND_QUERY, 12'd0, ihd_pkg::MODE_UNTIMED);
    tb_sess = 1;
    random_traffic(150);

    write_settings(12'd4095, 13'd8191, 14'd16383, 6'd63);
    random_traffic(40);

    // moderate settings, one of them across the timestamp wrap
    clock_ms = 32'hFFFF_FF00;
    for (int p = 0; p < 3; p++) begin
      write_settings(12'($urandom_range(600, 3000)), 13'($urandom_range(0, 300)),
                     14'($urandom_range(0, 10000)), 6'($urandom_range(1, 3)));
      random_traffic(110);
    end

    calm = 1;
    random_traffic(150);

    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || expected_status.size() != 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ihd_pkg.sv
src/ihd_if.sv
src/impact_hit_detector.sv
sim/tb_impact_hit_detector.sv
